>>> src/cswp_pkg.sv
// ----------------------------------------------------------------------------
// cswp_pkg - shared definitions for the cascaded steering and wheel PID
// Defaults, limits, register indexes, sequencer step codes and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cswp_pkg;

    // default parameter values
    localparam int CSWP_FRAC_BITS   = 16;
    localparam int CSWP_SPEED_WIDTH = 16;

    // fixed limits
    localparam int DUTY_MAX   = 9999;
    localparam int STEER_ILIM = 100;
    localparam int BIG_ERR    = 10;

    // register indexes
    localparam logic [2:0] REG_STEER_KP = 3'd0;
    localparam logic [2:0] REG_STEER_KI = 3'd1;
    localparam logic [2:0] REG_STEER_KD = 3'd2;
    localparam logic [2:0] REG_SPEED_KP = 3'd3;
    localparam logic [2:0] REG_SPEED_KI = 3'd4;
    localparam logic [2:0] REG_SPEED_KD = 3'd5;
    localparam logic [2:0] REG_CRUISE   = 3'd6;
    localparam logic [2:0] REG_CEILING  = 3'd7;

    // register reset values
    localparam logic [31:0] RST_STEER_KP = 32'd5898;
    localparam logic [31:0] RST_STEER_KI = 32'd0;
    localparam logic [31:0] RST_STEER_KD = 32'd0;
    localparam logic [31:0] RST_SPEED_KP = 32'd78643200;
    localparam logic [31:0] RST_SPEED_KI = 32'd2949120;
    localparam logic [31:0] RST_SPEED_KD = 32'd0;
    localparam logic [7:0]  RST_CRUISE   = 8'd7;
    localparam logic [13:0] RST_CEILING  = 14'd9999;

    // sequencer steps
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_A    = 5'd1;   // integral, derivative, A*smoothed
    localparam logic [4:0] ST_B    = 5'd2;   // B*d
    localparam logic [4:0] ST_C    = 5'd3;   // filter sum
    localparam logic [4:0] ST_D    = 5'd4;   // smoothed derivative, magnitude
    localparam logic [4:0] ST_E    = 5'd5;   // kd*int
    localparam logic [4:0] ST_F    = 5'd6;   // kd*frac
    localparam logic [4:0] ST_G    = 5'd7;   // kp*e, signed kd term
    localparam logic [4:0] ST_H    = 5'd8;   // ki*integral
    localparam logic [4:0] ST_I    = 5'd9;   // sum
    localparam logic [4:0] ST_J    = 5'd10;  // adjustment, targets
    localparam logic [4:0] W_A     = 5'd11;  // wheel error
    localparam logic [4:0] W_B     = 5'd12;  // kp*(err-e1)
    localparam logic [4:0] W_C     = 5'd13;  // ki*err
    localparam logic [4:0] W_D     = 5'd14;  // kd*dd, start divide
    localparam logic [4:0] W_E     = 5'd15;  // add kd term
    localparam logic [4:0] W_F     = 5'd16;  // wait divide, add integral term
    localparam logic [4:0] W_G     = 5'd17;  // duty update
    localparam logic [4:0] ST_OUT  = 5'd18;  // load result

    typedef struct packed {
        logic [4:0] step;
        logic       side;     // 0 left wheel, 1 right wheel
        logic       capture;  // take the input request
        logic       load;     // move result to the output register
    } t_cmd;

    typedef struct packed {
        logic big_err;   // |wheel error| above the threshold
        logic div_busy;
    } t_stat;

endpackage

`default_nettype wire

>>> src/cswp_ctrl.sv
// ----------------------------------------------------------------------------
// cswp_ctrl - sequencer for the steering and wheel PID datapath
// Steps through the steering loop, then each wheel, and hands the result
// to the output register once that is free.
// ----------------------------------------------------------------------------
`default_nettype none

module cswp_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  wire              i_m_tready,
    input  cswp_pkg::t_stat  i_stat,
    output cswp_pkg::t_cmd   o_cmd
);

    logic [4:0] r_state, n_state;
    logic       r_side, n_side;
    logic       r_valid, n_valid;
    logic       w_capture, w_load;

    assign w_capture = (r_state == cswp_pkg::ST_IDLE) && i_s_tvalid;
    assign w_load    = (r_state == cswp_pkg::ST_OUT) && (!r_valid || i_m_tready);

    // next state
    always_comb begin
        n_state = r_state;
        n_side  = r_side;
        case (r_state)
            cswp_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = cswp_pkg::ST_A;
                    n_side  = 1'b0;
                end
            end
            cswp_pkg::ST_J: n_state = cswp_pkg::W_A;
            cswp_pkg::W_F: begin
                if (!(i_stat.big_err && i_stat.div_busy)) n_state = cswp_pkg::W_G;
            end
            cswp_pkg::W_G: begin
                if (r_side) begin
                    n_state = cswp_pkg::ST_OUT;
                end else begin
                    n_state = cswp_pkg::W_A;
                    n_side  = 1'b1;
                end
            end
            cswp_pkg::ST_OUT: begin
                if (w_load) n_state = cswp_pkg::ST_IDLE;
            end
            default: begin
                if (r_state < cswp_pkg::ST_OUT) n_state = r_state + 5'd1;
                else n_state = cswp_pkg::ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        n_valid = r_valid;
        if (r_valid && i_m_tready) n_valid = 1'b0;
        if (w_load) n_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cswp_pkg::ST_IDLE;
            r_side  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_side  <= n_side;
            r_valid <= n_valid;
        end
    end

    assign o_s_tready    = (r_state == cswp_pkg::ST_IDLE);
    assign o_m_tvalid    = r_valid;
    assign o_cmd.step    = r_state;
    assign o_cmd.side    = r_side;
    assign o_cmd.capture = w_capture;
    assign o_cmd.load    = w_load;

endmodule

`default_nettype wire

>>> src/cswp_div10.sv
// ----------------------------------------------------------------------------
// cswp_div10 - iterative floor division by ten
// Eight quotient bits a cycle, most significant first; the sign is applied
// at the end with floor rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module cswp_div10 #(
    parameter int DW = 56
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire                 i_neg,
    input  wire  [DW-1:0]       i_mag,
    output logic                o_busy,
    output logic signed [DW:0]  o_quo
);

    localparam int NDIG = DW / 8;
    localparam int CW   = $clog2(NDIG + 1);

    logic [DW-1:0] r_num, n_num;
    logic [3:0]    r_rem, n_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_neg;

    // eight restoring steps on a remainder that stays below ten
    always_comb begin
        logic [4:0]    v_t;
        logic [DW-1:0] v_n;
        logic [3:0]    v_r;
        v_n = r_num;
        v_r = r_rem;
        for (int k = 0; k < 8; k++) begin
            v_t = {v_r, v_n[DW-1]};
            v_n = {v_n[DW-2:0], 1'b0};
            if (v_t >= 5'd10) begin
                v_t    = v_t - 5'd10;
                v_n[0] = 1'b1;
            end
            v_r = v_t[3:0];
        end
        n_num = v_n;
        n_rem = v_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NDIG);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_mag;
            r_rem <= '0;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    // floor: a negative dividend with remainder rounds one further down
    assign o_busy = r_busy;
    assign o_quo  = r_neg ? -($signed({1'b0, r_num}) + $signed({{DW{1'b0}}, (r_rem != 4'd0)}))
                          : $signed({1'b0, r_num});

endmodule

`default_nettype wire

>>> src/cswp_dp.sv
// ----------------------------------------------------------------------------
// cswp_dp - datapath of the steering and wheel PID
// Holds registers and loop state, one shared multiplier with a registered
// product, an accumulator, and the divide-by-ten unit.
// ----------------------------------------------------------------------------
`default_nettype none

module cswp_dp #(
    parameter int FRAC_BITS   = cswp_pkg::CSWP_FRAC_BITS,
    parameter int SPEED_WIDTH = cswp_pkg::CSWP_SPEED_WIDTH,
    parameter int ITW         = 48,
    parameter int OTW         = 64
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  cswp_pkg::t_cmd  i_cmd,
    output cswp_pkg::t_stat o_stat,
    input  wire  [ITW-1:0]  i_s_tdata,
    output logic [OTW-1:0]  o_m_tdata,
    input  wire             i_cfg_we,
    input  wire  [2:0]      i_cfg_idx,
    input  wire  [31:0]     i_cfg_data
);

    localparam int F    = FRAC_BITS;
    localparam int S    = SPEED_WIDTH;
    localparam int SW   = F + 13;                    // smoothed derivative
    localparam int OW   = (F + 14 > 33) ? F + 14 : 33; // multiplier operand
    localparam int PW   = 2 * OW;
    localparam int AW   = PW + 2;
    localparam int AFW  = F + 14;                    // duty accumulator
    localparam int EW   = S + 1;                     // wheel error
    localparam int DW   = ((S + 41) / 8) * 8;        // divider magnitude
    localparam int FA   = (9 * (2 ** F) + 5) / 10;
    localparam int FB   = (2 ** F) - FA;

    localparam logic signed [AW-1:0] UNIT  = $signed({{(AW-1){1'b0}}, 1'b1});
    localparam logic signed [AW-1:0] ONE_Q = UNIT <<< F;
    localparam logic signed [AW-1:0] HALF  = UNIT <<< (F - 1);
    localparam logic signed [AW-1:0] DMAX  = $signed(AW'(cswp_pkg::DUTY_MAX)) <<< F;
    localparam logic signed [AW-1:0] SMAX  = (UNIT <<< (S - 1)) - UNIT;
    localparam logic signed [AW-1:0] SMIN  = -SMAX - UNIT;

    // configuration
    logic [31:0] r_skp, r_ski, r_skd, r_vkp, r_vki, r_vkd;
    logic [7:0]  r_cruise;
    logic [13:0] r_ceil;

    // item and loop state
    logic [10:0]          r_e, r_sle;
    logic                 r_pos, r_neg;
    logic signed [S-1:0]  r_ls, r_rs, r_lt, r_rt;
    logic signed [7:0]    r_si;
    logic signed [11:0]   r_d;
    logic signed [SW-1:0] r_ss;
    logic [SW-1:0]        r_mag;
    logic                 r_msgn;
    logic signed [EW-1:0] r_err;
    logic signed [EW-1:0] r_e1 [2];
    logic signed [EW-1:0] r_e2 [2];
    logic [AFW-1:0]       r_dacc [2];
    logic [13:0]          r_duty [2];
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc, r_iterm;
    logic [OTW-1:0]       r_out;

    logic signed [OW-1:0] n_ma, n_mb;
    logic signed [11:0]   w_sisum, w_dn;
    logic signed [7:0]    w_si;
    logic signed [SW-1:0] w_ssn;
    logic signed [AW-1:0] w_prod, w_kt, w_adj, w_base, w_tp, w_tm;
    logic signed [AW-1:0] w_t3, w_nacc, w_cl, w_inc;
    logic signed [EW-1:0] w_e1, w_e2;
    logic signed [EW:0]   w_dp;
    logic signed [EW+1:0] w_dd;
    logic signed [S-1:0]  w_tsel, w_ssel;
    logic                 w_big, w_apply, w_div_busy, w_div_start;
    logic [13:0]          w_dint;
    logic signed [DW:0]   w_quo;

    function automatic logic signed [S-1:0] sat_s(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] c;
        c = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
        return c[S-1:0];
    endfunction

    // steering arithmetic
    assign w_prod  = AW'(r_prod);
    assign w_dn    = $signed({1'b0, r_e}) - $signed({1'b0, r_sle});
    assign w_sisum = 12'(r_si) + $signed({1'b0, r_e});
    assign w_si    = (w_sisum > 12'sd100) ? 8'(cswp_pkg::STEER_ILIM)
                   : ((w_sisum < -12'sd100) ? -8'(cswp_pkg::STEER_ILIM) : w_sisum[7:0]);
    assign w_ssn   = SW'(r_acc >>> F);
    assign w_kt    = r_acc + (w_prod >>> F);
    assign w_adj   = r_acc[AW-1] ? -((-r_acc) >>> F) : (r_acc >>> F);
    assign w_base  = $signed({{(AW-8){1'b0}}, r_cruise});
    assign w_tp    = w_base + w_adj;
    assign w_tm    = w_base - w_adj;

    // wheel arithmetic
    assign w_tsel  = i_cmd.side ? r_rt : r_lt;
    assign w_ssel  = i_cmd.side ? r_rs : r_ls;
    assign w_e1    = r_e1[i_cmd.side];
    assign w_e2    = r_e2[i_cmd.side];
    assign w_dp    = (EW+1)'(r_err) - (EW+1)'(w_e1);
    assign w_dd    = (EW+2)'(r_err) + (EW+2)'(w_e2) - ((EW+2)'(w_e1) <<< 1);
    assign w_big   = (r_err > EW'(cswp_pkg::BIG_ERR)) || (r_err < -EW'(cswp_pkg::BIG_ERR));
    assign w_t3    = w_prod + (w_prod <<< 1);
    assign w_inc   = r_acc;
    assign w_apply = (w_inc < -ONE_Q) || (w_inc > ONE_Q);
    assign w_nacc  = $signed({{(AW-AFW){1'b0}}, r_dacc[i_cmd.side]}) + (w_apply ? w_inc : '0);
    assign w_cl    = (w_nacc > DMAX) ? DMAX : ((w_nacc < 0) ? '0 : w_nacc);
    assign w_dint  = w_cl[AFW-1:F];

    assign w_div_start = (i_cmd.step == cswp_pkg::W_D) && w_big;

    cswp_div10 #(.DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_neg   (w_t3[AW-1]),
        .i_mag   (w_t3[AW-1] ? DW'(-w_t3) : DW'(w_t3)),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    // multiplier operand select
    always_comb begin
        n_ma = '0;
        n_mb = '0;
        case (i_cmd.step)
            cswp_pkg::ST_A: begin
                n_ma = OW'(FA);
                n_mb = OW'(r_ss);
            end
            cswp_pkg::ST_B: begin
                n_ma = OW'(FB);
                n_mb = OW'(r_d);
            end
            cswp_pkg::ST_E: begin
                n_ma = $signed({{(OW-32){1'b0}}, r_skd});
                n_mb = $signed({{(OW-SW+F){1'b0}}, r_mag[SW-1:F]});
            end
            cswp_pkg::ST_F: begin
                n_ma = $signed({{(OW-32){1'b0}}, r_skd});
                n_mb = $signed({{(OW-F){1'b0}}, r_mag[F-1:0]});
            end
            cswp_pkg::ST_G: begin
                n_ma = $signed({{(OW-32){1'b0}}, r_skp});
                n_mb = $signed({{(OW-11){1'b0}}, r_e});
            end
            cswp_pkg::ST_H: begin
                n_ma = $signed({{(OW-32){1'b0}}, r_ski});
                n_mb = OW'(r_si);
            end
            cswp_pkg::W_B: begin
                n_ma = $signed({{(OW-32){1'b0}}, r_vkp});
                n_mb = OW'(w_dp);
            end
            cswp_pkg::W_C: begin
                n_ma = $signed({{(OW-32){1'b0}}, r_vki});
                n_mb = OW'(r_err);
            end
            cswp_pkg::W_D: begin
                n_ma = $signed({{(OW-32){1'b0}}, r_vkd});
                n_mb = OW'(w_dd);
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
    end

    // configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skp    <= cswp_pkg::RST_STEER_KP;
            r_ski    <= cswp_pkg::RST_STEER_KI;
            r_skd    <= cswp_pkg::RST_STEER_KD;
            r_vkp    <= cswp_pkg::RST_SPEED_KP;
            r_vki    <= cswp_pkg::RST_SPEED_KI;
            r_vkd    <= cswp_pkg::RST_SPEED_KD;
            r_cruise <= cswp_pkg::RST_CRUISE;
            r_ceil   <= cswp_pkg::RST_CEILING;
            r_si     <= '0;
            r_sle    <= '0;
            r_ss     <= '0;
            r_e1[0]  <= '0;
            r_e1[1]  <= '0;
            r_e2[0]  <= '0;
            r_e2[1]  <= '0;
            r_dacc[0] <= '0;
            r_dacc[1] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cswp_pkg::REG_STEER_KP: r_skp    <= i_cfg_data;
                    cswp_pkg::REG_STEER_KI: r_ski    <= i_cfg_data;
                    cswp_pkg::REG_STEER_KD: r_skd    <= i_cfg_data;
                    cswp_pkg::REG_SPEED_KP: r_vkp    <= i_cfg_data;
                    cswp_pkg::REG_SPEED_KI: r_vki    <= i_cfg_data;
                    cswp_pkg::REG_SPEED_KD: r_vkd    <= i_cfg_data;
                    cswp_pkg::REG_CRUISE:   r_cruise <= i_cfg_data[7:0];
                    cswp_pkg::REG_CEILING:  r_ceil   <= i_cfg_data[13:0];
                    default: ;
                endcase
            end
            case (i_cmd.step)
                cswp_pkg::ST_A: begin
                    r_si  <= w_si;
                    r_sle <= r_e;
                end
                cswp_pkg::ST_D: r_ss <= w_ssn;
                cswp_pkg::W_G: begin
                    r_dacc[i_cmd.side] <= w_cl[AFW-1:0];
                    r_e2[i_cmd.side]   <= w_e1;
                    r_e1[i_cmd.side]   <= r_err;
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_prod <= n_ma * n_mb;
        if (i_cmd.capture) begin
            r_e   <= i_s_tdata[10] ? 11'(-$signed(i_s_tdata[10:0])) : i_s_tdata[10:0];
            r_pos <= !i_s_tdata[10] && (i_s_tdata[10:0] != 11'd0);
            r_neg <= i_s_tdata[10];
            r_ls  <= $signed(i_s_tdata[11+S-1:11]);
            r_rs  <= $signed(i_s_tdata[11+2*S-1:11+S]);
        end
        if (i_cmd.load) begin
            r_out <= OTW'({r_rt, r_lt, r_duty[1], r_duty[0]});
        end
        case (i_cmd.step)
            cswp_pkg::ST_A: r_d <= w_dn;
            cswp_pkg::ST_B: r_acc <= w_prod;
            cswp_pkg::ST_C: r_acc <= r_acc + (w_prod <<< F) + HALF;
            cswp_pkg::ST_D: begin
                r_mag  <= w_ssn[SW-1] ? SW'(-w_ssn) : SW'(w_ssn);
                r_msgn <= w_ssn[SW-1];
            end
            cswp_pkg::ST_F: r_acc <= w_prod;
            cswp_pkg::ST_G: r_acc <= r_msgn ? -w_kt : w_kt;
            cswp_pkg::ST_H: r_acc <= r_acc + w_prod;
            cswp_pkg::ST_I: r_acc <= r_acc + w_prod;
            cswp_pkg::ST_J: begin
                r_lt <= r_pos ? sat_s(w_tp) : (r_neg ? sat_s(w_tm) : sat_s(w_base));
                r_rt <= r_pos ? sat_s(w_tm) : (r_neg ? sat_s(w_tp) : sat_s(w_base));
            end
            cswp_pkg::W_A: r_err <= EW'(w_tsel) - EW'(w_ssel);
            cswp_pkg::W_C: r_acc <= w_prod;
            cswp_pkg::W_D: r_iterm <= w_prod;
            cswp_pkg::W_E: r_acc <= r_acc + w_prod;
            cswp_pkg::W_F: begin
                if (!(w_big && w_div_busy)) begin
                    r_acc <= r_acc + (w_big ? AW'(w_quo) : r_iterm);
                end
            end
            cswp_pkg::W_G: r_duty[i_cmd.side] <= (w_dint > r_ceil) ? r_ceil : w_dint;
            default: ;
        endcase
    end

    assign o_m_tdata       = r_out;
    assign o_stat.big_err  = w_big;
    assign o_stat.div_busy = w_div_busy;

endmodule

`default_nettype wire

>>> src/cascaded_steer_and_wheel_pid.sv
// ----------------------------------------------------------------------------
// cascaded_steer_and_wheel_pid - steering PID feeding two wheel speed PIDs
// Top level: stream ports, configuration write port, sequencer and datapath.
// ----------------------------------------------------------------------------
// One request per control tick: a line offset and two wheel speeds go in, two
// duties and two wheel targets come out. From acceptance to result an item
// runs ten steering steps and seven steps per wheel through one shared
// multiplier, and per wheel also waits on the divide-by-ten unit, which works
// on a DW-bit magnitude, when the wheel error exceeds ten (DW = 56 at the default
// speed width). The input is taken only while the sequencer is idle; a result
// waits in the output register while the next item is worked on. Gains are
// unsigned with FRAC_BITS fraction bits; writes take effect at once and are
// meant for an idle block.
`default_nettype none

module cascaded_steer_and_wheel_pid #(
    parameter int FRAC_BITS   = cswp_pkg::CSWP_FRAC_BITS,
    parameter int SPEED_WIDTH = cswp_pkg::CSWP_SPEED_WIDTH,
    localparam int ITW = ((11 + 2 * SPEED_WIDTH + 7) / 8) * 8,
    localparam int OTW = ((28 + 2 * SPEED_WIDTH + 7) / 8) * 8
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             s_axis_tvalid,
    output logic            s_axis_tready,
    // line_offset, left_wheel_speed, right_wheel_speed
    input  wire  [ITW-1:0]  s_axis_tdata,
    output logic            m_axis_tvalid,
    input  wire             m_axis_tready,
    // left_duty, right_duty, left_target, right_target
    output logic [OTW-1:0]  m_axis_tdata,
    input  wire             i_cfg_we,
    input  wire  [2:0]      i_cfg_idx,
    input  wire  [31:0]     i_cfg_data
);

    cswp_pkg::t_cmd  w_cmd;
    cswp_pkg::t_stat w_stat;

    cswp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    cswp_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .SPEED_WIDTH (SPEED_WIDTH),
        .ITW         (ITW),
        .OTW         (OTW)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tdata  (s_axis_tdata),
        .o_m_tdata  (m_axis_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

endmodule

`default_nettype wire

>>> src/cswp_chk.sv
// ----------------------------------------------------------------------------
// cswp_chk - port-level checks for the steering and wheel PID
// Watches the top-level stream ports; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module cswp_chk #(
    parameter int OTW = 64
) (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            s_axis_tvalid,
    input wire            s_axis_tready,
    input wire            m_axis_tvalid,
    input wire            m_axis_tready,
    input wire [OTW-1:0]  m_axis_tdata
);

    // a held result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // nothing offered straight after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // one request at a time: busy after acceptance
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while working");

    // duties within the motor range
    a_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[13:0] <= 14'd9999)
                       && (m_axis_tdata[27:14] <= 14'd9999))
        else $error("duty out of range");

endmodule

bind cascaded_steer_and_wheel_pid cswp_chk #(.OTW(OTW)) u_cswp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench for cascaded_steer_and_wheel_pid
// Drives line offset and wheel speed requests through the stream input, with
// bursty input, a stalling output and one long output hold-off. Predicts duty
// and wheel targets in a scoreboard class and checks every result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int F   = cswp_pkg::CSWP_FRAC_BITS;
    localparam int SW  = cswp_pkg::CSWP_SPEED_WIDTH;
    localparam int ITW = ((11 + 2 * SW + 7) / 8) * 8;
    localparam int OTW = ((28 + 2 * SW + 7) / 8) * 8;
    localparam longint ONE_Q = longint'(1) << F;
    localparam longint FILT_A = (9 * ONE_Q + 5) / 10;
    localparam longint FILT_B = ONE_Q - FILT_A;
    localparam longint DUTY_TOP = longint'(cswp_pkg::DUTY_MAX) * ONE_Q;
    localparam longint SPD_HI = (longint'(1) << (SW - 1)) - 1;
    localparam longint SPD_LO = -(longint'(1) << (SW - 1));

    typedef struct packed {
        logic [13:0]   left_duty;
        logic [13:0]   right_duty;
        logic [SW-1:0] left_target;
        logic [SW-1:0] right_target;
    } t_drive;

    int n_errors = 0;

    // one line per mismatch
    task automatic report_mismatch(input string what, input longint got, input longint exp);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
        n_errors++;
    endtask

    function automatic longint floor_div(input longint v, input longint d);
        longint q;
        q = v / d;
        if ((v % d) != 0 && v < 0) q--;
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // scoreboard: controller prediction and queue of expected drives
    // ------------------------------------------------------------------------
    class drive_scoreboard;
        longint gain[8];
        longint integ, last_e, smooth;
        longint e1[2], e2[2], acc[2];
        t_drive pending[$];

        function void clear();
            gain[cswp_pkg::REG_STEER_KP] = cswp_pkg::RST_STEER_KP;
            gain[cswp_pkg::REG_STEER_KI] = cswp_pkg::RST_STEER_KI;
            gain[cswp_pkg::REG_STEER_KD] = cswp_pkg::RST_STEER_KD;
            gain[cswp_pkg::REG_SPEED_KP] = cswp_pkg::RST_SPEED_KP;
            gain[cswp_pkg::REG_SPEED_KI] = cswp_pkg::RST_SPEED_KI;
            gain[cswp_pkg::REG_SPEED_KD] = cswp_pkg::RST_SPEED_KD;
            gain[cswp_pkg::REG_CRUISE]   = cswp_pkg::RST_CRUISE;
            gain[cswp_pkg::REG_CEILING]  = cswp_pkg::RST_CEILING;
            integ = 0; last_e = 0; smooth = 0;
            foreach (e1[i]) begin
                e1[i] = 0; e2[i] = 0; acc[i] = 0;
            end
        endfunction

        function void write_reg(input logic [2:0] idx, input logic [31:0] val);
            if (idx == cswp_pkg::REG_CRUISE) gain[idx] = val[7:0];
            else if (idx == cswp_pkg::REG_CEILING) gain[idx] = val[13:0];
            else gain[idx] = val;
        endfunction

        function longint steer_adjust(input longint e);
            longint d, mag, kdt, s;
            integ += e;
            if (integ > cswp_pkg::STEER_ILIM) integ = cswp_pkg::STEER_ILIM;
            if (integ < -cswp_pkg::STEER_ILIM) integ = -cswp_pkg::STEER_ILIM;
            d = e - last_e;
            smooth = floor_div(FILT_A * smooth + FILT_B * d * ONE_Q + ONE_Q / 2, ONE_Q);
            last_e = e;
            mag = smooth < 0 ? -smooth : smooth;
            kdt = gain[cswp_pkg::REG_STEER_KD] * (mag >>> F)
                + ((gain[cswp_pkg::REG_STEER_KD] * (mag & (ONE_Q - 1))) >>> F);
            if (smooth < 0) kdt = -kdt;
            s = gain[cswp_pkg::REG_STEER_KP] * e + gain[cswp_pkg::REG_STEER_KI] * integ + kdt;
            return s / ONE_Q;
        endfunction

        function longint wheel_duty(input int w, input longint tgt, input longint spd);
            longint err, aerr, it, inc, duty;
            err = tgt - spd;
            aerr = err < 0 ? -err : err;
            if (aerr > cswp_pkg::BIG_ERR)
                it = floor_div(3 * gain[cswp_pkg::REG_SPEED_KI] * err, 10);
            else
                it = gain[cswp_pkg::REG_SPEED_KI] * err;
            inc = gain[cswp_pkg::REG_SPEED_KP] * (err - e1[w]) + it
                + gain[cswp_pkg::REG_SPEED_KD] * (err + e2[w] - 2 * e1[w]);
            if (inc < -ONE_Q || inc > ONE_Q) acc[w] += inc;
            if (acc[w] > DUTY_TOP) acc[w] = DUTY_TOP;
            if (acc[w] < 0) acc[w] = 0;
            e2[w] = e1[w];
            e1[w] = err;
            duty = acc[w] >>> F;
            if (duty > gain[cswp_pkg::REG_CEILING]) duty = gain[cswp_pkg::REG_CEILING];
            return duty;
        endfunction

        function void note_request(input logic [ITW-1:0] data);
            longint off, ls, rs, adj, lt, rt;
            t_drive r;
            off = longint'($signed(data[10:0]));
            ls  = longint'($signed(data[11 +: SW]));
            rs  = longint'($signed(data[11 + SW +: SW]));
            adj = steer_adjust(off < 0 ? -off : off);
            lt = gain[cswp_pkg::REG_CRUISE];
            rt = gain[cswp_pkg::REG_CRUISE];
            if (off > 0) begin
                lt = lt + adj; rt = rt - adj;
            end else if (off < 0) begin
                lt = lt - adj; rt = rt + adj;
            end
            lt = lt > SPD_HI ? SPD_HI : (lt < SPD_LO ? SPD_LO : lt);
            rt = rt > SPD_HI ? SPD_HI : (rt < SPD_LO ? SPD_LO : rt);
            r.left_duty    = 14'(wheel_duty(0, lt, ls));
            r.right_duty   = 14'(wheel_duty(1, rt, rs));
            r.left_target  = SW'(lt);
            r.right_target = SW'(rt);
            pending.push_back(r);
        endfunction

        task check_result(input logic [OTW-1:0] data);
            t_drive got, exp;
            got.right_target = data[28 + SW +: SW];
            got.left_target  = data[28 +: SW];
            got.right_duty   = data[14 +: 14];
            got.left_duty    = data[13:0];
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", data[31:0], 0);
            end else begin
                exp = pending.pop_front();
                if (got.left_duty !== exp.left_duty)
                    report_mismatch("left_duty", got.left_duty, exp.left_duty);
                if (got.right_duty !== exp.right_duty)
                    report_mismatch("right_duty", got.right_duty, exp.right_duty);
                if (got.left_target !== exp.left_target)
                    report_mismatch("left_target", $signed(got.left_target),
                                    $signed(exp.left_target));
                if (got.right_target !== exp.right_target)
                    report_mismatch("right_target", $signed(got.right_target),
                                    $signed(exp.right_target));
            end
        endtask
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [ITW-1:0] s_axis_tdata = '0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [OTW-1:0] m_axis_tdata;
    logic           i_cfg_we = 1'b0;
    logic [2:0]     i_cfg_idx = '0;
    logic [31:0]    i_cfg_data = '0;

    drive_scoreboard sb = new();
    bit hold_off = 1'b0;
    bit sink_on = 1'b0;

    always #4 i_clk = ~i_clk;

    cascaded_steer_and_wheel_pid i_dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    // monitor: note accepted requests, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // receiver: own stall pattern, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!sink_on || hold_off) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 9) == 0);
    end

    // configuration write while idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        sb.write_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one request, waits for acceptance
    task automatic send_tick(input logic [10:0] off, input logic [SW-1:0] ls,
                             input logic [SW-1:0] rs);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ls, rs, off} == 0 ? '0 : ITW'({rs, ls, off});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic pause_input();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [SW-1:0] rand_speed(input int near);
        int v;
        case ($urandom_range(0, 5))
            0: return SW'($urandom);
            1: return {1'b0, {(SW-1){1'b1}}};
            2: return {1'b1, {(SW-1){1'b0}}};
            default: begin
                v = near + $signed($urandom_range(0, 40)) - 20;
                return SW'(v);
            end
        endcase
    endfunction

    // random phase: mostly plausible speeds near the targets, some noise
    task automatic random_phase(input int count);
        int left, burst;
        logic [10:0] off;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && left > 0) begin
                if ($urandom_range(0, 7) == 0) off = 11'($urandom);
                else off = 11'($signed($urandom_range(0, 60)) - 30);
                send_tick(off, rand_speed(int'(sb.gain[cswp_pkg::REG_CRUISE])),
                          rand_speed(int'(sb.gain[cswp_pkg::REG_CRUISE])));
                burst--; left--;
            end
            if ($urandom_range(0, 2) != 0) pause_input();
        end
        drain();
    endtask

    logic [31:0] cfg_set[8];

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sb.clear();
        sink_on = 1'b1;

        // directed: field extremes and sign cases with reset gains
        send_tick(11'd0, '0, '0);
        send_tick(11'h3ff, '0, '0);
        send_tick(11'h400, '0, '0);
        send_tick(11'h001, {1'b0, {(SW-1){1'b1}}}, {1'b1, {(SW-1){1'b0}}});
        send_tick(11'h7ff, {1'b1, {(SW-1){1'b0}}}, {1'b0, {(SW-1){1'b1}}});
        send_tick(11'd5, SW'(7), SW'(7));
        send_tick(11'd5, SW'(17), SW'(-3));
        send_tick(11'h7f0, SW'(10), SW'(4));
        send_tick(11'd0, '1, '1);
        send_tick(11'd20, SW'(2), SW'(30));
        drain();

        // directed: maximum gains, saturated targets, ceiling at zero
        write_reg(cswp_pkg::REG_STEER_KP, 32'hffff_ffff);
        write_reg(cswp_pkg::REG_STEER_KI, 32'hffff_ffff);
        write_reg(cswp_pkg::REG_STEER_KD, 32'hffff_ffff);
        write_reg(cswp_pkg::REG_SPEED_KP, 32'hffff_ffff);
        write_reg(cswp_pkg::REG_SPEED_KI, 32'hffff_ffff);
        write_reg(cswp_pkg::REG_SPEED_KD, 32'hffff_ffff);
        write_reg(cswp_pkg::REG_CRUISE, 32'd255);
        write_reg(cswp_pkg::REG_CEILING, 32'd0);
        send_tick(11'h3ff, SW'(0), SW'(0));
        send_tick(11'h400, SW'(100), SW'(-100));
        send_tick(11'd3, '1, '0);
        send_tick(11'd0, '0, '1);
        drain();
        write_reg(cswp_pkg::REG_CEILING, 32'd9999);
        write_reg(cswp_pkg::REG_CRUISE, 32'd0);
        send_tick(11'h200, SW'(0), SW'(0));
        send_tick(11'h600, SW'(5), SW'(-5));
        drain();

        // random phases under several settings, the first with most gains at their reset values
        for (int ph = 0; ph < 6; ph++) begin
            cfg_set[cswp_pkg::REG_STEER_KP] = ph == 0 ? cswp_pkg::RST_STEER_KP
                                                      : $urandom_range(0, 3 << F);
            cfg_set[cswp_pkg::REG_STEER_KI] = ph == 0 ? 0 : $urandom_range(0, 1 << (F - 2));
            cfg_set[cswp_pkg::REG_STEER_KD] = ph == 5 ? 32'hffff_ffff
                                                      : $urandom_range(0, 2 << F);
            cfg_set[cswp_pkg::REG_SPEED_KP] = ph == 0 ? cswp_pkg::RST_SPEED_KP : $urandom;
            cfg_set[cswp_pkg::REG_SPEED_KI] = ph == 0 ? cswp_pkg::RST_SPEED_KI
                                                      : $urandom_range(0, 60 << F);
            cfg_set[cswp_pkg::REG_SPEED_KD] = ph < 2 ? 0 : $urandom_range(0, 20 << F);
            cfg_set[cswp_pkg::REG_CRUISE]   = ph == 4 ? 255 : $urandom_range(0, 40);
            cfg_set[cswp_pkg::REG_CEILING]  = ph == 3 ? $urandom_range(0, 300) : 9999;
            for (int r = 0; r < 8; r++) write_reg(3'(r), cfg_set[r]);
            if (ph == 2) begin
                // receiver holds off while the sender keeps offering
                hold_off = 1'b1;
                fork
                    random_phase(200);
                    begin
                        repeat (600) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join
            end else begin
                random_phase(200);
            end
        end

        if (n_errors == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // run limit
    initial begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
